>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define B2D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b2d check failed: same-cycle rule");

// next-cycle implication
`define B2D_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b2d check failed: next-cycle rule");

`endif

>>> rtl/core/b2d_pkg.sv
`timescale 1ns / 1ps

package b2d_pkg;

   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 6;
   localparam int DIGIT_W    = 4;
   localparam int DIGIT_SLOTS = 20;
   localparam int STEP_CNT_W = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]     ASCII_ZERO = 6'd48;
   localparam logic [STEP_CNT_W-1:0] LAST_STEP  = STEP_CNT_W'(VALUE_W - 1);

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   // sequencer commands to the datapath
   typedef struct packed {
      logic load;
      logic shift;
   } dp_ctrl_type;

   // datapath flags back to the sequencer
   typedef struct packed {
      logic wide;
      logic digit_zero;
   } dp_status_type;

endpackage

>>> rtl/core/b2d_if.sv
`timescale 1ns / 1ps

interface b2d_req_if;
   import b2d_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface b2d_rsp_if;
   import b2d_pkg::*;

   logic     valid;
   logic     ready;
   char_type digit_char;
   logic     last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

>>> rtl/core/b2d_step.sv
`timescale 1ns / 1ps

module b2d_step #(
   parameter int DIGITS = 20
) (
   input  logic [DIGITS*b2d_pkg::DIGIT_W-1:0] bcd_i,
   input  logic                               msb_i,
   output logic [DIGITS*b2d_pkg::DIGIT_W-1:0] bcd_o,
   output logic                               spill_o
);
   import b2d_pkg::*;

   localparam int BCD_W = DIGITS * DIGIT_W;

   logic [BCD_W-1:0] adj;

   // add 3 to every digit of five or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_i[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign bcd_o   = {adj[BCD_W-2:0], msb_i};
   assign spill_o = adj[BCD_W-1];

endmodule

>>> rtl/core/b2d_dp.sv
`timescale 1ns / 1ps

module b2d_dp #(
   parameter int DIGITS = 20,
   parameter int IDX_W  = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  b2d_pkg::dp_ctrl_type   ctrl_i,
   input  b2d_pkg::value_type     value_i,
   input  logic [IDX_W-1:0]       idx_i,
   output b2d_pkg::dp_status_type status_o,
   output b2d_pkg::char_type      digit_char_o
);
   import b2d_pkg::*;

   localparam int BCD_W = DIGITS * DIGIT_W;

   value_type        bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             wide_ff, wide_in;
   logic [BCD_W-1:0] bcd_step;
   logic             spill;
   digit_type        digit;

   b2d_step #(.DIGITS(DIGITS)) u_step (
      .bcd_i   (bcd_ff),
      .msb_i   (bin_ff[VALUE_W-1]),
      .bcd_o   (bcd_step),
      .spill_o (spill)
   );

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      wide_in = wide_ff;
      if (ctrl_i.load) begin
         bin_in  = value_i;
         bcd_in  = '0;
         wide_in = 1'b0;
      end else if (ctrl_i.shift) begin
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in  = bcd_step;
         // any bit past the top digit means more digits than kept
         wide_in = wide_ff | spill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
      end else begin
         wide_ff <= wide_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digit                = bcd_ff[idx_i*DIGIT_W +: DIGIT_W];
   assign status_o.wide        = wide_ff;
   assign status_o.digit_zero  = (digit == '0);
   assign digit_char_o         = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};

endmodule

>>> rtl/core/b2d_ctrl.sv
`timescale 1ns / 1ps

module b2d_ctrl #(
   parameter int DIGITS = 20,
   parameter int IDX_W  = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_last,
   input  b2d_pkg::dp_status_type status_i,
   output b2d_pkg::dp_ctrl_type   ctrl_o,
   output logic [IDX_W-1:0]       idx_o
);
   import b2d_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DIGITS - 1);

   logic [1:0]            state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      ctrl_o.load  = 1'b0;
      ctrl_o.shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_o.load = 1'b1;
               cnt_in      = LAST_STEP;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl_o.shift = 1'b1;
            if (cnt_ff == '0) begin
               idx_in   = TOP_IDX;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff - STEP_CNT_W'(1);
            end
         end
         ST_SCAN: begin
            // drop leading zeros unless the value overflows the kept digits
            if (!status_i.wide && idx_ff != '0 && status_i.digit_zero) begin
               idx_in = idx_ff - IDX_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   assign rsp_last = (idx_ff == '0);
   assign idx_o    = idx_ff;

endmodule

>>> rtl/core/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// channel | dir | payload                  | transfer
// req     | in  | value[63:0]              | valid && ready
// rsp     | out | digit_char[5:0], last    | valid && ready
//
// one value is loaded, shifted through the shared adjust unit with one
// shift-add-3 step per value bit, scanned for leading zeros, then sent
// digit by digit, most significant first, while rsp is ready
// req_ready is high only when idle; a stalled rsp holds digit and index
// synchronous active-high reset returns the sequencer to idle

module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = 20
) (
   input logic        clock,
   input logic        reset,
   b2d_req_if.sink    req_chan,
   b2d_rsp_if.source  rsp_chan
);
   import b2d_pkg::*;

   localparam int DIGITS = (MAX_DIGITS > DIGIT_SLOTS) ? DIGIT_SLOTS :
                           ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
   localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   dp_ctrl_type      dp_ctrl;
   dp_status_type    dp_status;
   logic [IDX_W-1:0] idx;

   b2d_ctrl #(.DIGITS(DIGITS), .IDX_W(IDX_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_last  (rsp_chan.last_digit),
      .status_i  (dp_status),
      .ctrl_o    (dp_ctrl),
      .idx_o     (idx)
   );

   b2d_dp #(.DIGITS(DIGITS), .IDX_W(IDX_W)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl_i       (dp_ctrl),
      .value_i      (req_chan.value),
      .idx_i        (idx),
      .status_o     (dp_status),
      .digit_char_o (rsp_chan.digit_char)
   );

endmodule

>>> rtl/core/b2d_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b2d_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input b2d_pkg::char_type       rsp_digit_char,
   input logic                    rsp_last_digit
);
   import b2d_pkg::*;

   logic req_xfer;
   logic rsp_xfer;
   logic digit_ok;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign digit_ok = (rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= ASCII_ZERO + 6'd9);

   `B2D_ASSERT_IMP(a_no_accept_while_emitting, clock, reset, req_xfer, !rsp_valid)
   `B2D_ASSERT_NXT(a_busy_after_accept, clock, reset, req_xfer, !req_ready && !rsp_valid)
   `B2D_ASSERT_IMP(a_digit_range, clock, reset, rsp_valid, digit_ok)
   `B2D_ASSERT_NXT(a_run_continues, clock, reset, rsp_xfer && !rsp_last_digit, rsp_valid)
   `B2D_ASSERT_NXT(a_idle_after_last, clock, reset, rsp_xfer && rsp_last_digit, req_ready && !rsp_valid)

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_digit_char (rsp_chan.digit_char),
   .rsp_last_digit (rsp_chan.last_digit)
);
